FILE: hdl/cmic_pkg.sv
// Shared types, widths and register codes of the color matrix convert unit.
package cmic_pkg;

  localparam int COEF_BITS = 21;
  localparam int NUM_COMP = 3;
  localparam int SAMPLE_W = 16;
  localparam int OFF_W = 17;
  localparam int VAL_W = SAMPLE_W + 2;
  localparam int PROD_W = VAL_W + COEF_BITS;
  localparam int SUM_W = PROD_W + 3;
  localparam int FRAC_W = 5;
  localparam int DIR_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 63;
  localparam int ROW_W = NUM_COMP * COEF_BITS;

  localparam logic [FRAC_W-1:0] MAX_FRAC = 5'd20;
  localparam logic [FRAC_W-1:0] MIN_SAMPLE_BITS = 5'd8;
  localparam logic [FRAC_W-1:0] MAX_SAMPLE_BITS = 5'd16;
  localparam logic [FRAC_W-1:0] RESET_SAMPLE_BITS = 5'd8;
  localparam logic [FRAC_W-1:0] RESET_FRAC_BITS = 5'd14;

  // Direction codes; the unused code behaves as luma only.
  localparam logic [DIR_W-1:0] DIR_RGB_TO_YUV = 2'd0;
  localparam logic [DIR_W-1:0] DIR_YUV_TO_RGB = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RGB_TO_Y = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UNUSED = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_OFFSET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RGB_OFFSET = 3'd7;

  // Decoded configuration seen by every datapath stage.
  typedef struct packed {
    logic [FRAC_W-1:0]                         frac;
    logic                                      reverse;
    logic                                      luma_only;
    logic [SAMPLE_W-1:0]                       limit;
    logic [OFF_W-1:0]                          center;
    logic [NUM_COMP-1:0][NUM_COMP-1:0][COEF_BITS-1:0] weight;
    logic signed [OFF_W-1:0]                   luma_off;
    logic signed [OFF_W-1:0]                   rgb_off;
  } cfg_t;

endpackage

FILE: hdl/cmic_adjust.sv
// Input register stage: applies the per-sample offsets ahead of the products.
module cmic_adjust import cmic_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [SAMPLE_W-1:0]     sample_i [NUM_COMP],
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [VAL_W-1:0] val_o [NUM_COMP]
);

  logic                    vld_q;
  logic signed [VAL_W-1:0] val_d [NUM_COMP];
  logic signed [VAL_W-1:0] val_q [NUM_COMP];

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      val_d[k] = $signed({2'b00, sample_i[k]});
      if (cfg_i.reverse) begin
        if (k == 0) begin
          val_d[k] = val_d[k] + VAL_W'(cfg_i.luma_off);
        end else begin
          val_d[k] = val_d[k] - $signed({1'b0, cfg_i.center});
        end
      end else begin
        val_d[k] = val_d[k] + VAL_W'(cfg_i.rgb_off);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      val_q <= val_d;
    end
  end

  assign valid_o = vld_q;
  assign val_o = val_q;

endmodule

FILE: hdl/cmic_mult.sv
// Product stage: nine signed sample-by-weight products, registered.
module cmic_mult import cmic_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [VAL_W-1:0]  val_i [NUM_COMP],
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [PROD_W-1:0] prod_o [NUM_COMP][NUM_COMP]
);

  logic                     vld_q;
  logic signed [PROD_W-1:0] prod_d [NUM_COMP][NUM_COMP];
  logic signed [PROD_W-1:0] prod_q [NUM_COMP][NUM_COMP];

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        prod_d[k][j] = PROD_W'(val_i[j]) * PROD_W'($signed(cfg_i.weight[k][j]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = vld_q;
  assign prod_o = prod_q;

endmodule

FILE: hdl/cmic_sum.sv
// Result stage: row sums with rounding and offset, clamp, shift, output register.
module cmic_sum import cmic_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [PROD_W-1:0] prod_i [NUM_COMP][NUM_COMP],
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [SAMPLE_W-1:0]      result_o [NUM_COMP]
);

  logic                    vld_q;
  logic [MAX_FRAC-1:0]     rounding;
  logic signed [SUM_W-1:0] top;
  logic signed [OFF_W-1:0] offs [NUM_COMP];
  logic signed [SUM_W-1:0] sum [NUM_COMP];
  logic signed [SUM_W-1:0] clamped [NUM_COMP];
  logic [SAMPLE_W-1:0]     res_d [NUM_COMP];
  logic [SAMPLE_W-1:0]     res_q [NUM_COMP];

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    rounding = '0;
    if (cfg_i.frac != '0) begin
      rounding = MAX_FRAC'(1) << (cfg_i.frac - FRAC_W'(1));
    end
    top = $signed(SUM_W'(cfg_i.limit) << cfg_i.frac);
    for (int k = 0; k < NUM_COMP; k++) begin
      if (cfg_i.reverse) begin
        offs[k] = cfg_i.rgb_off;
      end else if (k == 0) begin
        offs[k] = cfg_i.luma_off;
      end else begin
        offs[k] = $signed(cfg_i.center);
      end
      sum[k] = SUM_W'(prod_i[k][0]) + SUM_W'(prod_i[k][1]) + SUM_W'(prod_i[k][2])
             + $signed(SUM_W'(rounding)) + (SUM_W'(offs[k]) <<< cfg_i.frac);
      if (sum[k] < 0) begin
        clamped[k] = '0;
      end else if (sum[k] > top) begin
        clamped[k] = top;
      end else begin
        clamped[k] = sum[k];
      end
      res_d[k] = SAMPLE_W'(clamped[k] >> cfg_i.frac);
      // Luma only: chroma results are forced to zero.
      if (cfg_i.luma_only && k != 0) begin
        res_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q;
  assign result_o = res_q;

endmodule

FILE: hdl/color_matrix_integer_convert_unit.sv
// Top level of the fixed-point color matrix convert unit.
// The unit converts one pixel of three samples per clock while the output is
// not stalled, between RGB and YUV (or RGB to luma only) with a programmable
// 3x3 matrix of signed 21-bit weights. Every item passes three register
// stages: an input register that applies the sample offsets, a product
// register holding the nine products, and the result register after rounding,
// offset, clamp and shift. The sustained rate is one item per clock while the
// output is not stalled, since every stage takes a new item in the same cycle
// its current one moves on. Each stage holds one item and takes a new one
// whenever it is empty or its item moves on, so a stalled result does not
// block the stages behind it until they fill.
// Configuration is written through a separate index/data port that is always
// ready; write it only while no item is in flight.
module color_matrix_integer_convert_unit import cmic_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_a_i,
  input  logic [SAMPLE_W-1:0]   sample_b_i,
  input  logic [SAMPLE_W-1:0]   sample_c_i,
  // pixel output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SAMPLE_W-1:0]   result_a_o,
  output logic [SAMPLE_W-1:0]   result_b_o,
  output logic [SAMPLE_W-1:0]   result_c_o
);

  logic [FRAC_W-1:0]             sample_bits_q;
  logic [FRAC_W-1:0]             frac_bits_q;
  logic [DIR_W-1:0]              direction_q;
  logic [NUM_COMP-1:0][ROW_W-1:0] coef_q;
  logic signed [OFF_W-1:0]       luma_off_q;
  logic signed [OFF_W-1:0]       rgb_off_q;

  logic [FRAC_W-1:0] bits_sat;
  cfg_t              cfg;

  logic                     s1_valid, s1_ready;
  logic                     s2_valid, s2_ready;
  logic                     s3_ready;
  logic [SAMPLE_W-1:0]      sample [NUM_COMP];
  logic signed [VAL_W-1:0]  val [NUM_COMP];
  logic signed [PROD_W-1:0] prod [NUM_COMP][NUM_COMP];
  logic [SAMPLE_W-1:0]      result [NUM_COMP];

  // Register file; the write port is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bits_q <= RESET_SAMPLE_BITS;
      frac_bits_q   <= RESET_FRAC_BITS;
      direction_q   <= DIR_RGB_TO_YUV;
      coef_q        <= '0;
      luma_off_q    <= '0;
      rgb_off_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SAMPLE_BITS: sample_bits_q <= cfg_data_i[FRAC_W-1:0];
        REG_FRAC_BITS:   frac_bits_q   <= cfg_data_i[FRAC_W-1:0];
        REG_DIRECTION:   direction_q   <= cfg_data_i[DIR_W-1:0];
        REG_COEF_ROW_0:  coef_q[0]     <= cfg_data_i[ROW_W-1:0];
        REG_COEF_ROW_1:  coef_q[1]     <= cfg_data_i[ROW_W-1:0];
        REG_COEF_ROW_2:  coef_q[2]     <= cfg_data_i[ROW_W-1:0];
        REG_LUMA_OFFSET: luma_off_q    <= $signed(cfg_data_i[OFF_W-1:0]);
        REG_RGB_OFFSET:  rgb_off_q     <= $signed(cfg_data_i[OFF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Decode: saturate the sample width and fraction bits, derive the
  // clamp limit and chroma center, split the weights.
  always_comb begin
    if (sample_bits_q < MIN_SAMPLE_BITS) begin
      bits_sat = MIN_SAMPLE_BITS;
    end else if (sample_bits_q > MAX_SAMPLE_BITS) begin
      bits_sat = MAX_SAMPLE_BITS;
    end else begin
      bits_sat = sample_bits_q;
    end
    cfg.frac      = (frac_bits_q > MAX_FRAC) ? MAX_FRAC : frac_bits_q;
    cfg.reverse   = (direction_q == DIR_YUV_TO_RGB);
    cfg.luma_only = (direction_q != DIR_RGB_TO_YUV) && (direction_q != DIR_YUV_TO_RGB);
    cfg.limit     = SAMPLE_W'((OFF_W'(1) << bits_sat) - OFF_W'(1));
    cfg.center    = OFF_W'(1) << (bits_sat - FRAC_W'(1));
    for (int k = 0; k < NUM_COMP; k++) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        cfg.weight[k][j] = coef_q[k][j*COEF_BITS +: COEF_BITS];
      end
    end
    cfg.luma_off = luma_off_q;
    cfg.rgb_off  = rgb_off_q;
  end

  assign sample[0] = sample_a_i;
  assign sample[1] = sample_b_i;
  assign sample[2] = sample_c_i;
  assign in_ready_o = s1_ready;

  cmic_adjust u_adjust (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (in_valid_i),
    .ready_o  (s1_ready),
    .sample_i (sample),
    .valid_o  (s1_valid),
    .ready_i  (s2_ready),
    .val_o    (val)
  );

  cmic_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .val_i   (val),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .prod_o  (prod)
  );

  cmic_sum u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (s2_valid),
    .ready_o  (s3_ready),
    .prod_i   (prod),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (result)
  );

  assign result_a_o = result[0];
  assign result_b_o = result[1];
  assign result_c_o = result[2];

endmodule

FILE: hdl/cmic_checker.sv
// Port-level checks of the color matrix convert unit, bound to the top level.
module cmic_checker import cmic_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [SAMPLE_W-1:0] result_a_o,
  input logic [SAMPLE_W-1:0] result_b_o,
  input logic [SAMPLE_W-1:0] result_c_o
);

  logic       in_acc, out_acc;
  logic [2:0] inflight_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Count items accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(result_a_o) && $stable(result_b_o) && $stable(result_c_o))
    else $error("result changed while stalled");

  // Input only stalls when the output is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // No result without an item in flight.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without accepted item");

  // The pipeline holds at most three items.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("more items in flight than stages");

endmodule

bind color_matrix_integer_convert_unit cmic_checker u_cmic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_a_o  (result_a_o),
  .result_b_o  (result_b_o),
  .result_c_o  (result_c_o)
);

FILE: verif/tb_color_matrix_integer_convert_unit.sv
// Testbench for the color matrix convert unit: directed and random pixels checked by a scoreboard.
module tb_color_matrix_integer_convert_unit;
  import cmic_pkg::*;

  // Pipeline depth of the datapath, used to pad the drain wait.
  localparam int PIPE_LATENCY = 3;
  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_WEIGHT = (1 << (COEF_BITS - 1)) - 1;
  localparam int MIN_WEIGHT = -(1 << (COEF_BITS - 1));

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_TOGGLE
  } rx_mode_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] c;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   sample_a_i = '0;
  logic [SAMPLE_W-1:0]   sample_b_i = '0;
  logic [SAMPLE_W-1:0]   sample_c_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0]   result_a_o;
  logic [SAMPLE_W-1:0]   result_b_o;
  logic [SAMPLE_W-1:0]   result_c_o;

  // Scoreboard: mirrors the register file, converts each accepted pixel and
  // holds the converted pixels in acceptance order.
  class pixel_scoreboard;
    logic [FRAC_W-1:0]      sample_bits;
    logic [FRAC_W-1:0]      frac_bits;
    logic [DIR_W-1:0]       direction;
    logic [CFG_DATA_W-1:0]  coef_row [NUM_COMP];
    logic signed [OFF_W-1:0] luma_offset;
    logic signed [OFF_W-1:0] rgb_offset;
    pixel_t                 expected_pixels [$];
    int                     failures;

    function new();
      sample_bits = RESET_SAMPLE_BITS;
      frac_bits = RESET_FRAC_BITS;
      direction = DIR_RGB_TO_YUV;
      foreach (coef_row[k]) coef_row[k] = '0;
      luma_offset = '0;
      rgb_offset = '0;
      failures = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_SAMPLE_BITS: sample_bits = data[FRAC_W-1:0];
        REG_FRAC_BITS:   frac_bits = data[FRAC_W-1:0];
        REG_DIRECTION:   direction = data[DIR_W-1:0];
        REG_COEF_ROW_0:  coef_row[0] = data;
        REG_COEF_ROW_1:  coef_row[1] = data;
        REG_COEF_ROW_2:  coef_row[2] = data;
        REG_LUMA_OFFSET: luma_offset = data[OFF_W-1:0];
        REG_RGB_OFFSET:  rgb_offset = data[OFF_W-1:0];
        default: ;
      endcase
    endfunction

    // Largest sample value, with the sample width saturated into its legal range.
    function longint sample_limit();
      int unsigned bits;
      bits = sample_bits;
      if (bits < MIN_SAMPLE_BITS) bits = MIN_SAMPLE_BITS;
      if (bits > MAX_SAMPLE_BITS) bits = MAX_SAMPLE_BITS;
      return (longint'(1) << bits) - 1;
    endfunction

    function pixel_t convert_pixel(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                   logic [SAMPLE_W-1:0] c);
      int unsigned frac;
      longint lim, center, scale, rounding, top, acc;
      longint val [NUM_COMP];
      longint offs [NUM_COMP];
      logic signed [COEF_BITS-1:0] w;
      logic [SAMPLE_W-1:0] res [NUM_COMP];
      frac = (frac_bits > MAX_FRAC) ? MAX_FRAC : frac_bits;
      lim = sample_limit();
      center = (lim + 1) / 2;
      scale = longint'(1) << frac;
      rounding = (frac != 0) ? scale / 2 : 0;
      top = lim * scale;
      val[0] = longint'(a);
      val[1] = longint'(b);
      val[2] = longint'(c);
      if (direction == DIR_YUV_TO_RGB) begin
        // Reverse: shift luma, take the chroma center away, offset every output.
        val[0] += luma_offset;
        val[1] -= center;
        val[2] -= center;
        foreach (offs[k]) offs[k] = rgb_offset;
      end else begin
        foreach (val[k]) val[k] += rgb_offset;
        offs[0] = luma_offset;
        offs[1] = center;
        offs[2] = center;
      end
      for (int k = 0; k < NUM_COMP; k++) begin
        if (k > 0 && direction >= DIR_RGB_TO_Y) begin
          res[k] = '0;
        end else begin
          acc = rounding + offs[k] * scale;
          for (int j = 0; j < NUM_COMP; j++) begin
            w = coef_row[k][j*COEF_BITS +: COEF_BITS];
            acc += longint'(w) * val[j];
          end
          if (acc < 0) acc = 0;
          else if (acc > top) acc = top;
          res[k] = SAMPLE_W'(acc >> frac);
        end
      end
      return {res[0], res[1], res[2]};
    endfunction

    function void note_accepted(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                logic [SAMPLE_W-1:0] c);
      expected_pixels.push_back(convert_pixel(a, b, c));
    endfunction

    function void compare_field(string name, logic [SAMPLE_W-1:0] want,
                                logic [SAMPLE_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                               logic [SAMPLE_W-1:0] c);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("result with no pending item: result_a=%0d result_b=%0d result_c=%0d", a, b, c);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("result_a", want.a, a);
      compare_field("result_b", want.b, b);
      compare_field("result_c", want.c, c);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  pixel_scoreboard sb;
  rx_mode_e        rx_mode = RX_ALWAYS;
  int unsigned     rx_cycle = 0;
  int unsigned     rx_hold = 0;
  int unsigned     idle_cycles = 0;

  color_matrix_integer_convert_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_a_i  (sample_a_i),
    .sample_b_i  (sample_b_i),
    .sample_c_i  (sample_c_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_a_o  (result_a_o),
    .result_b_o  (result_b_o),
    .result_c_o  (result_c_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: periodically switch to a random stall pattern, including stretches
  // with no stall at all and long back-pressure runs.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[5:0] == 6'd0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_RARELY: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold <= rx_hold - 1;
        end else begin
          out_ready_i <= ~out_ready_i;
          rx_hold <= $urandom_range(0, 30);
        end
      end
    endcase
  end

  // Monitor both pixel channels; check results before noting new items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(result_a_o, result_b_o, result_c_o);
      if (in_valid_i && in_ready_o) sb.note_accepted(sample_a_i, sample_b_i, sample_c_i);
    end
  end

  // Watchdog: end the run when no channel moves anything for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [CFG_DATA_W-1:0] pack_row(int w0, int w1, int w2);
    return {w2[COEF_BITS-1:0], w1[COEF_BITS-1:0], w0[COEF_BITS-1:0]};
  endfunction

  // Mostly weights within plus or minus two at the current fraction width;
  // sometimes raw random bits that saturate.
  function automatic logic [CFG_DATA_W-1:0] random_row(int unsigned frac_eff);
    int mag;
    int w [NUM_COMP];
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'({$urandom(), $urandom()});
    mag = (frac_eff >= COEF_BITS - 2) ? MAX_WEIGHT : (2 << frac_eff);
    foreach (w[j]) w[j] = int'($urandom_range(0, 2 * mag)) - mag;
    return pack_row(w[0], w[1], w[2]);
  endfunction

  function automatic logic [OFF_W-1:0] random_offset();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return OFF_W'(int'($urandom_range(0, 510)) - 255);
      default: return OFF_W'($urandom());
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(longint lim);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SAMPLE_W'(lim);
      2: return SAMPLE_W'($urandom());
      default: return SAMPLE_W'($urandom_range(0, int'(lim)));
    endcase
  endfunction

  // Present one pixel and hold it until the unit takes it. Valid is left high
  // so the next pixel can follow back to back.
  task automatic send_pixel(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                            input logic [SAMPLE_W-1:0] c);
    in_valid_i <= 1'b1;
    sample_a_i <= a;
    sample_b_i <= b;
    sample_c_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every converted pixel has come out, then let the
  // pipeline settle.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Write all eight registers with the unit idle. With noisy set, fill the
  // unused upper data bits with random junk.
  task automatic configure(input logic [FRAC_W-1:0] bits, input logic [FRAC_W-1:0] frac,
                           input logic [DIR_W-1:0] dir, input logic [CFG_DATA_W-1:0] row0,
                           input logic [CFG_DATA_W-1:0] row1,
                           input logic [CFG_DATA_W-1:0] row2,
                           input logic [OFF_W-1:0] loff, input logic [OFF_W-1:0] roff,
                           input bit noisy);
    logic [CFG_DATA_W-1:0] value [8];
    logic [CFG_DATA_W-1:0] noise;
    drain_pipeline();
    noise = noisy ? CFG_DATA_W'({$urandom(), $urandom()}) : '0;
    value[REG_SAMPLE_BITS] = {noise[CFG_DATA_W-1:FRAC_W], bits};
    value[REG_FRAC_BITS] = {noise[CFG_DATA_W-1:FRAC_W], frac};
    value[REG_DIRECTION] = {noise[CFG_DATA_W-1:DIR_W], dir};
    value[REG_COEF_ROW_0] = row0;
    value[REG_COEF_ROW_1] = row1;
    value[REG_COEF_ROW_2] = row2;
    value[REG_LUMA_OFFSET] = {noise[CFG_DATA_W-1:OFF_W], loff};
    value[REG_RGB_OFFSET] = {noise[CFG_DATA_W-1:OFF_W], roff};
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i <= value[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(CFG_IDX_W'(i), value[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One random setting followed by a stream of random pixels. The sender runs
  // in bursts with gaps, except in phases picked to run without idling, and
  // may pause mid-stream until the unit is empty.
  task automatic run_random_phase(input int phase, input int count);
    logic [FRAC_W-1:0] bits, frac;
    logic [DIR_W-1:0] dir;
    int unsigned frac_eff, burst_left, gap;
    longint lim;
    int pause_at;
    bit bursty;
    bits = ($urandom_range(0, 5) == 0) ? FRAC_W'($urandom_range(0, 31))
                                       : FRAC_W'($urandom_range(8, 16));
    frac = ($urandom_range(0, 5) == 0) ? FRAC_W'($urandom_range(0, 31))
                                       : FRAC_W'($urandom_range(0, 20));
    dir = DIR_W'($urandom_range(0, 3));
    frac_eff = (frac > MAX_FRAC) ? MAX_FRAC : frac;
    configure(bits, frac, dir, random_row(frac_eff), random_row(frac_eff),
              random_row(frac_eff), random_offset(), random_offset(), 1'b1);
    lim = sb.sample_limit();
    pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? int'($urandom_range(0, count - 1))
                                                         : -1;
    bursty = (phase != 1) && ($urandom_range(0, 3) != 0);
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_pipeline();
      send_pixel(random_sample(lim), random_sample(lim), random_sample(lim));
      if (bursty) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: zero matrix, so only the rounding and center terms show.
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);

    // Studio-range RGB to YUV, 8-bit samples; include a sample above the limit.
    configure(5'd8, 5'd14, DIR_RGB_TO_YUV, pack_row(1868, 9617, 4899),
              pack_row(8192, -5427, -2765), pack_row(-1332, -6860, 8192),
              17'sd16, 17'sd0, 1'b0);
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd255, 16'd255, 16'd255);
    send_pixel(16'd255, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd0, 16'd255);
    send_pixel(16'hFFFF, 16'h0000, 16'hAAAA);

    // YUV back to RGB with a negative luma shift on the input.
    configure(5'd8, 5'd14, DIR_YUV_TO_RGB, pack_row(16384, 29032, 0),
              pack_row(16384, -5638, -11698), pack_row(16384, 0, 22970),
              -17'sd16, 17'sd0, 1'b0);
    send_pixel(16'd16, 16'd128, 16'd128);
    send_pixel(16'd235, 16'd240, 16'd16);
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd255, 16'd255, 16'd255);

    // Luma only at 10 bits; chroma outputs must read zero.
    configure(5'd10, 5'd14, DIR_RGB_TO_Y, pack_row(1868, 9617, 4899),
              pack_row(8192, -5427, -2765), pack_row(-1332, -6860, 8192),
              17'sd64, -17'sd64, 1'b0);
    send_pixel(16'd1023, 16'd1023, 16'd1023);
    send_pixel(16'h5555, 16'hAAAA, 16'h03FF);

    // Unused direction code behaves as luma only.
    configure(5'd10, 5'd14, DIR_UNUSED, pack_row(1868, 9617, 4899),
              pack_row(8192, -5427, -2765), pack_row(-1332, -6860, 8192),
              17'sd64, -17'sd64, 1'b0);
    send_pixel(16'd512, 16'd100, 16'd900);

    // Extreme weights and offsets at 16 bits with no fraction bits.
    configure(5'd16, 5'd0, DIR_RGB_TO_YUV, pack_row(MAX_WEIGHT, MAX_WEIGHT, MAX_WEIGHT),
              pack_row(MIN_WEIGHT, MIN_WEIGHT, MIN_WEIGHT), pack_row(1, 0, 0),
              17'h0FFFF, 17'h10000, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h8000, 16'h0001, 16'h7FFF);

    // Oversized sample and fraction widths saturate to 16 and 20.
    configure(5'd31, 5'd31, DIR_YUV_TO_RGB, pack_row(MAX_WEIGHT, 0, 0),
              pack_row(0, MAX_WEIGHT, 0), pack_row(0, 0, MAX_WEIGHT),
              17'h10000, 17'h0FFFF, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
    send_pixel(16'h1234, 16'h8000, 16'h7FFF);

    // Undersized sample width saturates to 8; samples above the limit pass
    // into the sum unchanged.
    configure(5'd0, 5'd1, DIR_RGB_TO_YUV, pack_row(2, 0, 0), pack_row(0, 2, 0),
              pack_row(0, 0, -2), 17'sd0, 17'sd0, 1'b1);
    send_pixel(16'd300, 16'd0, 16'hFFFF);
    send_pixel(16'd128, 16'd128, 16'd128);

    for (int phase = 0; phase < 8; phase++) run_random_phase(phase, 50);

    drain_pipeline();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
